@@ design/blmt_pkg.sv @@
// ----------------------------------------------------------------------------
// Button long-press mode timer package
// Shared widths, register indexes, reset values and payload types.
// ----------------------------------------------------------------------------
package blmt_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int MS_W        = 16;
    localparam int TEMP_W      = 15;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE_MS     = 3'd0,
        REG_LONG_PRESS_MS   = 3'd1,
        REG_INFO_MS         = 3'd2,
        REG_UPDATE_MS       = 3'd3,
        REG_WARM_THRESHOLD  = 3'd4,
        REG_DISPLAY_PRESENT = 3'd5,
        REG_SENSOR_PRESENT  = 3'd6
    } t_cfg_idx;

    localparam logic [MS_W-1:0]          DEBOUNCE_RST   = 16'd50;
    localparam logic [MS_W-1:0]          LONG_PRESS_RST = 16'd2000;
    localparam logic [MS_W-1:0]          INFO_RST       = 16'd5000;
    localparam logic [MS_W-1:0]          UPDATE_RST     = 16'd2000;
    localparam logic signed [TEMP_W-1:0] WARM_RST       = 15'sd2800;
    localparam logic                     DISPLAY_RST    = 1'b1;
    localparam logic                     SENSOR_RST     = 1'b1;

    typedef struct packed {
        logic [MS_W-1:0]          debounce_ms;
        logic [MS_W-1:0]          long_press_ms;
        logic [MS_W-1:0]          info_ms;
        logic [MS_W-1:0]          update_ms;
        logic signed [TEMP_W-1:0] warm_threshold;
        logic                     display_present;
    } t_cfg;

    typedef struct packed {
        logic                     button_level;
        logic signed [TEMP_W-1:0] temp_centi;
        logic                     temp_valid;
        logic                     hum_valid;
    } t_item;

    typedef struct packed {
        logic button_state;
        logic press_event;
        logic long_press;
        logic info_mode;
        logic warn_led;
        logic sensor_ok;
        logic refresh;
        logic show_press_msg;
        logic sample_taken;
    } t_res;

endpackage

@@ design/blmt_in_if.sv @@
// ----------------------------------------------------------------------------
// Tick input channel
// Valid/ready channel carrying the raw button level and the sensor sample.
// ----------------------------------------------------------------------------
interface blmt_in_if
    import blmt_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic                     button_level;
    logic signed [TEMP_W-1:0] temp_centi;
    logic                     temp_valid;
    logic                     hum_valid;

    modport source (
        output valid, button_level, temp_centi, temp_valid, hum_valid,
        input  ready
    );
    modport sink (
        input  valid, button_level, temp_centi, temp_valid, hum_valid,
        output ready
    );
endinterface

@@ design/blmt_out_if.sv @@
// ----------------------------------------------------------------------------
// Tick result channel
// Valid/ready channel carrying the button, mode and sensor flags of one tick.
// ----------------------------------------------------------------------------
interface blmt_out_if;
    logic valid;
    logic ready;
    logic button_state;
    logic press_event;
    logic long_press;
    logic info_mode;
    logic warn_led;
    logic sensor_ok;
    logic refresh;
    logic show_press_msg;
    logic sample_taken;

    modport source (
        output valid, button_state, press_event, long_press, info_mode, warn_led,
               sensor_ok, refresh, show_press_msg, sample_taken,
        input  ready
    );
    modport sink (
        input  valid, button_state, press_event, long_press, info_mode, warn_led,
               sensor_ok, refresh, show_press_msg, sample_taken,
        output ready
    );
endinterface

@@ design/blmt_cfg.sv @@
// ----------------------------------------------------------------------------
// Button long-press mode timer configuration registers
// Write-only register file decoded from the index of each write.
// ----------------------------------------------------------------------------
module blmt_cfg
    import blmt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // The sensor presence flag only matters at reset, and reset restores its
    // default, so a write to it is accepted and has no lasting effect.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms     <= DEBOUNCE_RST;
            r_cfg.long_press_ms   <= LONG_PRESS_RST;
            r_cfg.info_ms         <= INFO_RST;
            r_cfg.update_ms       <= UPDATE_RST;
            r_cfg.warm_threshold  <= WARM_RST;
            r_cfg.display_present <= DISPLAY_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_DEBOUNCE_MS:     r_cfg.debounce_ms     <= i_cfg_data[MS_W-1:0];
                REG_LONG_PRESS_MS:   r_cfg.long_press_ms   <= i_cfg_data[MS_W-1:0];
                REG_INFO_MS:         r_cfg.info_ms         <= i_cfg_data[MS_W-1:0];
                REG_UPDATE_MS:       r_cfg.update_ms       <= i_cfg_data[MS_W-1:0];
                REG_WARM_THRESHOLD:  r_cfg.warm_threshold  <= $signed(i_cfg_data[TEMP_W-1:0]);
                REG_DISPLAY_PRESENT: r_cfg.display_present <= i_cfg_data[0];
                REG_SENSOR_PRESENT: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ design/blmt_core.sv @@
// ----------------------------------------------------------------------------
// Button long-press mode timer state and tick logic
// Holds the debounce, hold, info and update state and works out one tick.
// ----------------------------------------------------------------------------
module blmt_core
    import blmt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_step,
    input  t_item i_item,
    input  t_cfg  i_cfg,
    output t_res  o_res
);

    logic                   r_last_raw, n_last_raw;
    logic                   r_debounced, n_debounced;
    logic                   r_long_done, n_long_done;
    logic                   r_mode_info, n_mode_info;
    logic                   r_sensor_ready, n_sensor_ready;
    logic                   r_press_pending, n_press_pending;
    logic                   r_led_on, n_led_on;
    logic [COUNT_WIDTH-1:0] r_stable_cnt, n_stable_cnt;
    logic [COUNT_WIDTH-1:0] r_hold_cnt, n_hold_cnt;
    logic [COUNT_WIDTH-1:0] r_info_cnt, n_info_cnt;
    logic [COUNT_WIDTH-1:0] r_update_cnt, n_update_cnt;
    t_res                   w_res;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
        return (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic logic ge_ms(input logic [COUNT_WIDTH-1:0] c,
                                   input logic [MS_W-1:0]        t);
        return 33'(c) >= 33'(t);
    endfunction

    always_comb begin
        n_stable_cnt    = sat_inc(r_stable_cnt);
        n_hold_cnt      = sat_inc(r_hold_cnt);
        n_info_cnt      = sat_inc(r_info_cnt);
        n_update_cnt    = sat_inc(r_update_cnt);
        n_long_done     = r_long_done;
        n_mode_info     = r_mode_info;
        n_sensor_ready  = r_sensor_ready;
        n_press_pending = r_press_pending;
        n_led_on        = r_led_on;
        w_res           = '0;

        if (i_item.button_level != r_last_raw) begin
            n_stable_cnt = '0;
        end
        n_last_raw  = i_item.button_level;
        n_debounced = (33'(n_stable_cnt) > 33'(i_cfg.debounce_ms)) ?
                      i_item.button_level : r_debounced;

        if (r_debounced && !n_debounced) begin
            n_hold_cnt          = '0;
            n_long_done         = 1'b0;
            n_press_pending     = 1'b1;
            w_res.press_event   = 1'b1;
        end

        if (!n_debounced && !n_long_done && ge_ms(n_hold_cnt, i_cfg.long_press_ms)) begin
            n_mode_info      = 1'b1;
            n_info_cnt       = '0;
            n_long_done      = 1'b1;
            w_res.long_press = 1'b1;
            if (i_cfg.display_present) begin
                w_res.refresh = 1'b1;
            end
        end

        if (n_mode_info && ge_ms(n_info_cnt, i_cfg.info_ms)) begin
            n_mode_info = 1'b0;
            if (i_cfg.display_present) begin
                w_res.refresh = 1'b1;
                if (n_press_pending) begin
                    n_press_pending      = 1'b0;
                    w_res.show_press_msg = 1'b1;
                end
            end
        end

        if (ge_ms(n_update_cnt, i_cfg.update_ms)) begin
            if (r_sensor_ready && i_cfg.display_present) begin
                n_led_on = i_item.temp_valid &&
                           ($signed(i_item.temp_centi) > $signed(i_cfg.warm_threshold));
                if (!(i_item.temp_valid && i_item.hum_valid)) begin
                    n_sensor_ready = 1'b0;
                end
                w_res.refresh      = 1'b1;
                w_res.sample_taken = 1'b1;
                if (!n_mode_info && n_press_pending) begin
                    n_press_pending      = 1'b0;
                    w_res.show_press_msg = 1'b1;
                end
            end
            n_update_cnt = '0;
        end

        w_res.button_state = n_debounced;
        w_res.info_mode    = n_mode_info;
        w_res.warn_led     = n_led_on;
        w_res.sensor_ok    = n_sensor_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw      <= 1'b1;
            r_debounced     <= 1'b1;
            r_long_done     <= 1'b0;
            r_mode_info     <= 1'b0;
            r_sensor_ready  <= SENSOR_RST;
            r_press_pending <= 1'b0;
            r_led_on        <= 1'b0;
            r_stable_cnt    <= '0;
            r_hold_cnt      <= '0;
            r_info_cnt      <= '0;
            r_update_cnt    <= '0;
        end else if (i_step) begin
            r_last_raw      <= n_last_raw;
            r_debounced     <= n_debounced;
            r_long_done     <= n_long_done;
            r_mode_info     <= n_mode_info;
            r_sensor_ready  <= n_sensor_ready;
            r_press_pending <= n_press_pending;
            r_led_on        <= n_led_on;
            r_stable_cnt    <= n_stable_cnt;
            r_hold_cnt      <= n_hold_cnt;
            r_info_cnt      <= n_info_cnt;
            r_update_cnt    <= n_update_cnt;
        end
    end

    assign o_res = w_res;

`ifndef SYNTH
    a_msg_needs_refresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && w_res.show_press_msg |-> w_res.refresh)
        else $error("press message shown without a redraw");

    a_sample_needs_refresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && w_res.sample_taken |-> w_res.refresh && r_sensor_ready)
        else $error("sample taken without a ready sensor or a redraw");

    a_long_sets_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && w_res.long_press |=> r_long_done)
        else $error("long press did not latch its done flag");

    a_sensor_stays_failed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sensor_ready |=> !r_sensor_ready)
        else $error("failed sensor recovered without reset");
`endif

endmodule

@@ design/button_longpress_mode_timer.sv @@
// ----------------------------------------------------------------------------
// Button long-press mode timer
// Debounces a button, detects press and long press, times the info view and
// runs the periodic sensor update, one millisecond tick per transfer.
//
//   Channel   Direction  Transfer
//   i_in      in         one tick: raw button level, temperature, valid flags
//   o_res     out        one result per tick: button, mode, LED, sensor flags
//   i_cfg_*   in         register write, index and data, no read-back
//
// A tick passes through the input register and then the result register; a
// new tick is taken every cycle while the result is not stalled. The state
// update for a tick is combinational counter and compare logic. Reset is
// synchronous and active low and restores all registers but the input and
// result data registers. A stalled result holds its register; the input side
// keeps taking ticks until both registers are full.
// ----------------------------------------------------------------------------
module button_longpress_mode_timer
    import blmt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    blmt_in_if.sink               i_in,
    blmt_out_if.source            o_res
);

    logic  r_in_valid;
    logic  r_out_valid;
    t_item r_item;
    t_res  r_res;
    t_item w_item;
    t_res  w_res;
    t_cfg  w_cfg;
    logic  w_advance;

    assign w_item.button_level = i_in.button_level;
    assign w_item.temp_centi   = i_in.temp_centi;
    assign w_item.temp_valid   = i_in.temp_valid;
    assign w_item.hum_valid    = i_in.hum_valid;

    assign w_advance  = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    blmt_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    blmt_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_item  (r_item),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= w_item;
        end
        if (w_advance) begin
            r_res <= w_res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.button_state   = r_res.button_state;
    assign o_res.press_event    = r_res.press_event;
    assign o_res.long_press     = r_res.long_press;
    assign o_res.info_mode      = r_res.info_mode;
    assign o_res.warn_led       = r_res.warn_led;
    assign o_res.sensor_ok      = r_res.sensor_ok;
    assign o_res.refresh        = r_res.refresh;
    assign o_res.show_press_msg = r_res.show_press_msg;
    assign o_res.sample_taken   = r_res.sample_taken;

endmodule
